// ----- rtl/core/keyframe_pose_interpolator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe pose interpolator
// Shared implication forms, clocked on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSE_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_POSE_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define KPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kpi_pkg.sv -----
// ----------------------------------------------------------------------------
// kpi_pkg
// Types, constants and helpers shared by the pose interpolator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package kpi_pkg;
  localparam int NUM_PARTS   = 8;
  localparam int MAX_KEYS    = 16;
  localparam int NUM_MOTIONS = 8;
  localparam int NCOMP       = 6;

  localparam int MOT_W  = 3;
  localparam int KEY_W  = 4;
  localparam int PART_W = 3;
  localparam int COMP_W = 3;
  localparam int VAL_W  = 32;
  localparam int FRM_W  = 10;
  localparam int KCNT_W = 5;

  localparam int KADDR_W   = MOT_W + KEY_W + PART_W + COMP_W;
  localparam int KEY_DEPTH = 1 << KADDR_W;
  localparam int FADDR_W   = MOT_W + KEY_W;
  localparam int FRM_DEPTH = 1 << FADDR_W;

  localparam int PROD_W     = VAL_W + 1 + FRM_W + 1;   // signed diff x unsigned count
  localparam int DIV_RADIX  = 4;                       // quotient bits per cycle
  localparam int DIV_STEPS  = PROD_W / DIV_RADIX;
  localparam int DCNT_W     = 4;

  localparam logic [PART_W-1:0] FIRST_PART = PART_W'(1);
  localparam logic [PART_W-1:0] LAST_PART  = PART_W'(NUM_PARTS - 1);
  localparam logic [COMP_W-1:0] LAST_COMP  = COMP_W'(NCOMP - 1);
  localparam logic [KCNT_W-1:0] KCNT_MAX   = KCNT_W'(MAX_KEYS);

  typedef enum logic [1:0] {
    ACT_KEY    = 2'd0,
    ACT_FRAME  = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_SELECT = 2'd3
  } action_t;

  typedef struct packed {
    logic               key_we;
    logic [KADDR_W-1:0] key_waddr;
    logic               frm_we;
    logic [FADDR_W-1:0] frm_waddr;
    logic               frm_re;
    logic [FADDR_W-1:0] frm_raddr;
    logic               key_re;
    logic [KADDR_W-1:0] key_raddr_a;
    logic [KADDR_W-1:0] key_raddr_b;
    logic               mul;
    logic [FRM_W-1:0]   count;
    logic               div_load;
    logic               div_step;
    logic               acc;
    logic [COMP_W-1:0]  acc_comp;
    logic               emit;
    logic [PART_W-1:0]  emit_part;
    logic               emit_last;
  } cmd_t;

  typedef struct packed {
    logic [FRM_W-1:0] frames;
    logic             out_free;
  } sts_t;

  function automatic logic [KADDR_W-1:0] key_addr(input logic [MOT_W-1:0] m,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [PART_W-1:0] p,
                                                  input logic [COMP_W-1:0] c);
    return {m, k, p, c};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/keyframe_pose_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator_unit
// Plays stored keyframe motions, one linearly interpolated pose word per part.
// ----------------------------------------------------------------------------
// Load words (tuser 0 key component, 1 frame count) write the stores;
// select words (tuser 3) clear playback progress when the motion's
// restart_mask bit is set; tick words (tuser 2) play one frame. A playing tick
// emits seven words, parts 1 to 7, with tlast on part 7. Each of the 42
// components passes through store read, multiply, divider load, 11 radix-16
// divider steps and saturate; each part then adds an emit step, which waits
// on any output stall. A tick holds the input until its last word is emitted;
// the shared 44-bit divider steps take most of that time. Load and select
// words do not leave idle. A finished word waits in the output register while
// the next input word is taken. Stores hold garbage until written.
`default_nettype none
`include "keyframe_pose_interpolator_unit_macros.svh"
module keyframe_pose_interpolator_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [2:0] motion, [6:3] key_index, [9:7] part_index, [12:10] component,
  // [44:13] value, [54:45] frame_count, [55] loop_enable, [60:56] key_count
  input  wire logic [63:0]  in_tdata,
  // [1:0] action
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [2:0] part, [34:3] pos_x, [66:35] pos_y, [98:67] pos_z,
  // [130:99] rot_x, [162:131] rot_y, [194:163] rot_z
  output logic [199:0]      out_tdata,
  // last_part
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data
);
  import kpi_pkg::*;

  cmd_t ctl_cmd;
  sts_t dp_sts;

  kpi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .action      (action_t'(in_tuser)),
    .motion      (in_tdata[2:0]),
    .key_index   (in_tdata[6:3]),
    .part_index  (in_tdata[9:7]),
    .component   (in_tdata[12:10]),
    .loop_enable (in_tdata[55]),
    .key_count   (in_tdata[60:56]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (ctl_cmd),
    .sts         (dp_sts)
  );

  kpi_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctl_cmd),
    .sts         (dp_sts),
    .value       (in_tdata[44:13]),
    .frame_count (in_tdata[54:45]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // never overwrite a word still waiting on the output
  `KPI_ASSERT_NOW(a_emit_free, ctl_cmd.emit, dp_sts.out_free, "emit into busy output")
  // a loaded word shows up as valid
  `KPI_ASSERT_NEXT(a_emit_valid, ctl_cmd.emit, out_tvalid, "emitted word not valid")
  // no word is taken while a tick is still being worked
  `KPI_ASSERT_NOW(a_busy_hold, ctl_cmd.div_step || ctl_cmd.emit, !in_tready,
                  "input ready during tick")
endmodule
`default_nettype wire

// ----- rtl/core/kpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpi_ctrl
// Sequencer: decodes input words, holds playback progress, steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module kpi_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire kpi_pkg::action_t          action,
  input  wire logic [kpi_pkg::MOT_W-1:0] motion,
  input  wire logic [kpi_pkg::KEY_W-1:0] key_index,
  input  wire logic [kpi_pkg::PART_W-1:0] part_index,
  input  wire logic [kpi_pkg::COMP_W-1:0] component,
  input  wire logic                      loop_enable,
  input  wire logic [kpi_pkg::KCNT_W-1:0] key_count,
  input  wire logic                      cfg_wr_en,
  input  wire logic [7:0]                cfg_wr_data,
  output kpi_pkg::cmd_t                  cmd,
  input  wire kpi_pkg::sts_t             sts
);
  import kpi_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_LOAD = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         mask_r;
  logic [KEY_W-1:0]   cur_key_r, cur_key_nxt;
  logic [FRM_W-1:0]   fcnt_r, fcnt_nxt;
  logic [MOT_W-1:0]   mot_r, mot_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;
  logic [COMP_W-1:0]  comp_r, comp_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  logic               accept;
  logic [KCNT_W-1:0]  kc_sat;
  logic               at_end;
  logic [KEY_W-1:0]   key_next;
  logic [FRM_W-1:0]   fcnt_inc;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign kc_sat    = (key_count > KCNT_MAX) ? KCNT_MAX : key_count;
  assign at_end    = ({1'b0, cur_key_r} + KCNT_W'(1)) >= kc_sat;
  assign key_next  = cur_key_r + KEY_W'(1);
  assign fcnt_inc  = fcnt_r + FRM_W'(1);

  always_comb begin
    state_nxt   = state_r;
    cur_key_nxt = cur_key_r;
    fcnt_nxt    = fcnt_r;
    mot_nxt     = mot_r;
    part_nxt    = part_r;
    comp_nxt    = comp_r;
    dcnt_nxt    = dcnt_r;

    cmd             = '0;
    cmd.key_waddr   = key_addr(motion, key_index, part_index, component);
    cmd.frm_waddr   = {motion, key_index};
    cmd.frm_raddr   = {motion, at_end ? KEY_W'(0) : cur_key_r};
    cmd.key_raddr_a = key_addr(mot_r, cur_key_r, part_r, comp_r);
    cmd.key_raddr_b = key_addr(mot_r, key_next, part_r, comp_r);
    cmd.count       = fcnt_r;
    cmd.acc_comp    = comp_r;
    cmd.emit_part   = part_r;
    cmd.emit_last   = (part_r == LAST_PART);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_KEY:    cmd.key_we = (component <= LAST_COMP);
            ACT_FRAME:  cmd.frm_we = 1'b1;
            ACT_SELECT: begin
              if (mask_r[motion]) begin
                cur_key_nxt = '0;
                fcnt_nxt    = '0;
              end
            end
            ACT_TICK: begin
              if (!at_end || loop_enable) begin
                cmd.frm_re  = 1'b1;
                if (at_end) cur_key_nxt = '0;
                mot_nxt   = motion;
                part_nxt  = FIRST_PART;
                comp_nxt  = '0;
                state_nxt = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd.key_re = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (comp_r == LAST_COMP) begin
          state_nxt = ST_EMIT;
        end else begin
          comp_nxt  = comp_r + COMP_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (part_r == LAST_PART) begin
            // advance playback once per tick
            if (fcnt_inc >= sts.frames) begin
              cur_key_nxt = key_next;
              fcnt_nxt    = '0;
            end else begin
              fcnt_nxt = fcnt_inc;
            end
            state_nxt = ST_IDLE;
          end else begin
            part_nxt  = part_r + PART_W'(1);
            comp_nxt  = '0;
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mask_r    <= '0;
      cur_key_r <= '0;
      fcnt_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_key_r <= cur_key_nxt;
      fcnt_r    <= fcnt_nxt;
      if (cfg_wr_en) mask_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mot_r  <= mot_nxt;
    part_r <= part_nxt;
    comp_r <= comp_nxt;
    dcnt_r <= dcnt_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/kpi_datapath.sv -----
// ----------------------------------------------------------------------------
// kpi_datapath
// Key and frame stores, multiplier, radix-16 divider, saturation, output word.
// ----------------------------------------------------------------------------
`default_nettype none
module kpi_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kpi_pkg::cmd_t              cmd,
  output kpi_pkg::sts_t                   sts,
  input  wire logic [kpi_pkg::VAL_W-1:0]  value,
  input  wire logic [kpi_pkg::FRM_W-1:0]  frame_count,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [199:0]                    out_tdata,
  output logic                            out_tlast
);
  import kpi_pkg::*;

  logic [VAL_W-1:0] key_mem [KEY_DEPTH];
  logic [FRM_W-1:0] frm_mem [FRM_DEPTH];

  logic [VAL_W-1:0]         a_q, b_q, a_r;
  logic [FRM_W-1:0]         frames_q;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        dvd_r, dvd_nxt;
  logic [FRM_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r;
  logic [VAL_W-1:0]         res_r [NCOMP];
  logic                     out_valid_r;

  logic signed [VAL_W:0]    diff;
  logic signed [PROD_W:0]   quo;
  logic signed [PROD_W+1:0] sum;
  logic [VAL_W-1:0]         sat;
  logic [FRM_W:0]           trial;

  // stores
  always_ff @(posedge clk) begin
    if (cmd.key_we) key_mem[cmd.key_waddr] <= value;
    if (cmd.key_re) begin
      a_q <= key_mem[cmd.key_raddr_a];
      b_q <= key_mem[cmd.key_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frm_we) frm_mem[cmd.frm_waddr] <= frame_count;
    if (cmd.frm_re) frames_q <= frm_mem[cmd.frm_raddr];
  end

  assign diff = $signed({b_q[VAL_W-1], b_q}) - $signed({a_q[VAL_W-1], a_q});

  // restoring division, DIV_RADIX quotient bits per step
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_nxt, dvd_nxt[PROD_W-1]};
      if (trial >= {1'b0, frames_q}) begin
        rem_nxt = FRM_W'(trial - {1'b0, frames_q});
        dvd_nxt = {dvd_nxt[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FRM_W-1:0];
        dvd_nxt = {dvd_nxt[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    quo = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
    if (frames_q == '0) quo = '0;
    sum = $signed({{(PROD_W+2-VAL_W){a_r[VAL_W-1]}}, a_r}) + (PROD_W+2)'(quo);
    if (sum > $signed((PROD_W+2)'(32'h7fffffff)))
      sat = 32'h7fffffff;
    else if (sum < -$signed((PROD_W+2)'(33'h080000000)))
      sat = 32'h80000000;
    else
      sat = sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff * $signed({1'b0, cmd.count}));
      a_r    <= a_q;
    end
    if (cmd.div_load) begin
      neg_r <= prod_r[PROD_W-1];
      dvd_r <= prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.acc) res_r[cmd.acc_comp] <= sat;
    if (cmd.emit) begin
      out_tdata <= {5'b0, res_r[5], res_r[4], res_r[3], res_r[2], res_r[1], res_r[0],
                    cmd.emit_part};
      out_tlast <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.frames   = frames_q;
endmodule
`default_nettype wire
